// ===== design/tqe_pkg.sv =====
// package for the timer queue expiry engine
// shared constants, operation codes and the command and result beat types
// no dependencies
package tqe_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int SCAN_W      = $clog2(NUM_SLOTS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 64;
    localparam int ID_W        = 4;
    localparam int NT_W        = 32;

    localparam logic [TIME_W-1:0] INT_CAP = TIME_W'(64'd2147483647);

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_DEL,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic            is_last;
        logic [NT_W-1:0] next_timeout;
    } t_res;

endpackage

// ===== design/timer_queue_expiry_engine_unit.sv =====
// timer queue expiry engine, top level
// an add, delete or no-op scans the expiry ram once for the next timeout, then emits one result beat;
// a tick rescans once per due slot that it picks, then scans once more for the next timeout
// one command in the back end at a time, bounded by the expiry ram read port,
// which scans one slot per cycle; two commands can wait in the front queue
// reset: synchronous, active low; clears marks and queues, expiry and interval rams are not cleared
module timer_queue_expiry_engine_unit import tqe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beat side
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_mode,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TIME_W-1:0] i_expiry_time,
    input  logic [TIME_W-1:0] i_repeat_interval,
    input  logic [TIME_W-1:0] i_now,
    // result beat side
    output logic              empty,
    input  logic              pop,
    output logic              o_fired,
    output logic [ID_W-1:0]   o_fired_id,
    output logic              o_is_last,
    output logic signed [NT_W-1:0] o_next_timeout
);
    // front to back command handoff
    logic w_cmd_valid;
    logic w_cmd_take;
    t_cmd w_cmd;
    t_res w_res;

    // front: classify mode and slot range, buffer commands
    tqe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_mode            (i_mode),
        .i_timer_id        (i_timer_id),
        .i_expiry_time     (i_expiry_time),
        .i_repeat_interval (i_repeat_interval),
        .i_now             (i_now),
        .o_cmd_valid       (w_cmd_valid),
        .o_cmd             (w_cmd),
        .i_cmd_take        (w_cmd_take)
    );

    // back: slot table, expiry scans, re-arm and result queue
    tqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    // result beat fields
    assign o_fired        = w_res.fired;
    assign o_fired_id     = w_res.fired_id;
    assign o_is_last      = w_res.is_last;
    assign o_next_timeout = signed'(w_res.next_timeout);
endmodule

// ===== design/tqe_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module tqe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/tqe_front.sv =====
// front end: accepts input beats, classifies them into commands
// and holds them in a two entry command queue; depends on tqe_pkg
module tqe_front import tqe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_mode,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TIME_W-1:0] i_expiry_time,
    input  logic [TIME_W-1:0] i_repeat_interval,
    input  logic [TIME_W-1:0] i_now,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);
    t_cmd       w_cmd;
    logic       w_in_range;
    logic       w_push;
    logic       w_take;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign w_in_range = (32'(i_timer_id) < NUM_SLOTS);

    always_comb begin
        w_cmd.slot     = SLOT_W'(i_timer_id);
        w_cmd.expiry   = i_expiry_time;
        w_cmd.interval = i_repeat_interval;
        w_cmd.now      = i_now;
        case (i_mode)
            MODE_ADD:  w_cmd.op = w_in_range ? OP_ADD : OP_NOP;
            MODE_DEL:  w_cmd.op = w_in_range ? OP_DEL : OP_NOP;
            MODE_TICK: w_cmd.op = OP_TICK;
            default:   w_cmd.op = OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_take      = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_take);
        end
    end
endmodule

// ===== design/tqe_back.sv =====
// back end: runs one command at a time over the slot table, scans the expiry
// ram for picks and the next timeout, queues result beats; depends on tqe_pkg, tqe_ram
module tqe_back import tqe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_REARM,
        S_DIFF,
        S_SAT,
        S_EMIT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [NUM_SLOTS-1:0] r_pend;
    logic [NUM_SLOTS-1:0] r_live;
    logic [NUM_SLOTS-1:0] r_taken;
    logic [SCAN_W-1:0]   r_scan;
    logic [SLOT_W-1:0]   r_prev_slot;
    logic                r_prev_v;
    logic                r_found;
    logic [TIME_W-1:0]   r_best;
    logic [SLOT_W-1:0]   r_pick;
    logic                r_rpt;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_ids [MAX_RESULTS];
    logic [CNT_W-1:0]    r_emit;
    logic [TIME_W-1:0]   r_diff;
    logic                r_due;
    logic [NT_W-1:0]     r_nt;

    t_res                r_rq [2];
    logic                r_rwp;
    logic                r_rrp;
    logic [1:0]          r_rcnt;

    logic [SLOT_W-1:0]   w_exp_raddr;
    logic [TIME_W-1:0]   w_exp_rdata;
    logic [TIME_W-1:0]   w_int_rdata;
    logic                w_exp_we;
    logic [SLOT_W-1:0]   w_exp_waddr;
    logic [TIME_W-1:0]   w_exp_wdata;
    logic                w_int_we;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_rearm;
    logic                w_cand;
    logic                w_scan_end;
    logic                w_push;
    logic                w_pop;
    t_res                w_res;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign w_scan_end = (r_scan == SCAN_W'(NUM_SLOTS));
    assign w_exp_raddr = r_scan[SLOT_W-1:0];

    // saturating re-arm time
    assign w_sum   = {1'b0, r_cmd.now} + {1'b0, w_int_rdata};
    assign w_rearm = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    // candidate test for the slot whose expiry came back this cycle
    always_comb begin
        w_cand = r_prev_v && r_pend[r_prev_slot] && (!r_found || (w_exp_rdata < r_best));
        if (!r_rpt) begin
            w_cand = w_cand && !r_taken[r_prev_slot] && (w_exp_rdata <= r_cmd.now);
        end
    end

    always_comb begin
        w_exp_we    = 1'b0;
        w_exp_waddr = i_cmd.slot;
        w_exp_wdata = i_cmd.expiry;
        w_int_we    = o_cmd_take && (i_cmd.op == OP_ADD);
        if (o_cmd_take && (i_cmd.op == OP_ADD)) begin
            w_exp_we = 1'b1;
        end else if ((r_state == S_REARM) && (w_int_rdata != '0)) begin
            w_exp_we    = 1'b1;
            w_exp_waddr = r_pick;
            w_exp_wdata = w_rearm;
        end
    end

    tqe_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (w_exp_we),
        .i_waddr (w_exp_waddr),
        .i_wdata (w_exp_wdata),
        .i_raddr (w_exp_raddr),
        .o_rdata (w_exp_rdata)
    );

    tqe_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_int_ram (
        .i_clk   (i_clk),
        .i_we    (w_int_we),
        .i_waddr (i_cmd.slot),
        .i_wdata (i_cmd.interval),
        .i_raddr (r_pick),
        .o_rdata (w_int_rdata)
    );

    // result beat under construction
    always_comb begin
        w_res.fired        = (r_count != '0);
        w_res.fired_id     = (r_count != '0) ? ID_W'(r_ids[r_emit[IDX_W-1:0]]) : '0;
        w_res.is_last      = (r_count == '0) || (r_emit == (r_count - CNT_W'(1)));
        w_res.next_timeout = r_nt;
    end

    assign o_empty = (r_rcnt == 2'd0);
    assign o_res   = r_rq[r_rrp];
    assign w_push  = (r_state == S_EMIT) && (r_rcnt != 2'd2);
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_rq[r_rwp] <= w_res;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= '0;
            r_live   <= '0;
            r_taken  <= '0;
            r_prev_v <= 1'b0;
            r_found  <= 1'b0;
            r_scan   <= '0;
            r_rpt    <= 1'b0;
            r_count  <= '0;
            r_emit   <= '0;
            r_rwp    <= 1'b0;
            r_rrp    <= 1'b0;
            r_rcnt   <= 2'd0;
        end else begin
            if (w_push) begin
                r_rwp <= !r_rwp;
            end
            if (w_pop) begin
                r_rrp <= !r_rrp;
            end
            r_rcnt <= r_rcnt + 2'(w_push) - 2'(w_pop);

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_count  <= '0;
                        r_emit   <= '0;
                        r_taken  <= '0;
                        r_scan   <= '0;
                        r_found  <= 1'b0;
                        r_prev_v <= 1'b0;
                        r_rpt    <= (i_cmd.op != OP_TICK);
                        r_state  <= S_SCAN;
                        case (i_cmd.op)
                            OP_ADD: begin
                                r_pend[i_cmd.slot] <= 1'b1;
                                r_live[i_cmd.slot] <= 1'b1;
                            end
                            OP_DEL: begin
                                r_live[i_cmd.slot] <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_cand) begin
                        r_found <= 1'b1;
                        r_best  <= w_exp_rdata;
                        r_pick  <= r_prev_slot;
                    end
                    if (w_scan_end) begin
                        r_prev_v <= 1'b0;
                        r_state  <= r_rpt ? S_DIFF : S_DECIDE;
                    end else begin
                        r_prev_v    <= 1'b1;
                        r_prev_slot <= r_scan[SLOT_W-1:0];
                        r_scan      <= r_scan + SCAN_W'(1);
                    end
                end
                S_DECIDE: begin
                    // interval of the pick is read this cycle
                    r_scan  <= '0;
                    r_found <= 1'b0;
                    if (!r_found) begin
                        r_rpt   <= 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_taken[r_pick] <= 1'b1;
                        r_pend[r_pick]  <= 1'b0;
                        r_state         <= r_live[r_pick] ? S_REARM : S_SCAN;
                    end
                end
                S_REARM: begin
                    r_ids[r_count[IDX_W-1:0]] <= r_pick;
                    r_count <= r_count + CNT_W'(1);
                    if (w_int_rdata != '0) begin
                        r_pend[r_pick] <= 1'b1;
                    end else begin
                        r_live[r_pick] <= 1'b0;
                    end
                    // stop picking once the result cap is reached
                    if (r_count == CNT_W'(MAX_RESULTS - 1)) begin
                        r_rpt <= 1'b1;
                    end
                    r_state <= S_SCAN;
                end
                S_DIFF: begin
                    r_diff <= r_best - r_cmd.now;
                    r_due  <= (r_best <= r_cmd.now);
                    if (!r_found) begin
                        r_nt    <= {NT_W{1'b1}};
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_due) begin
                        r_nt <= '0;
                    end else if (r_diff > INT_CAP) begin
                        r_nt <= NT_W'(INT_CAP);
                    end else begin
                        r_nt <= r_diff[NT_W-1:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_push) begin
                        if (w_res.is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit <= r_emit + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/tqe_checker.sv =====
// port level checks for the timer queue expiry engine
// bound to timer_queue_expiry_engine_unit; depends on tqe_pkg
module tqe_checker import tqe_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic              o_fired,
    input logic [ID_W-1:0]   o_fired_id,
    input logic              o_is_last,
    input logic [NT_W-1:0]   o_next_timeout
);
    // queues come out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a beat without a firing is the only beat of its command
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_fired) |-> (o_is_last && (o_fired_id == '0)))
        else $error("non-firing beat not last or has an id");

    // next timeout is -1 or non-negative
    a_nt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_next_timeout[NT_W-1] || (o_next_timeout == {NT_W{1'b1}})))
        else $error("next timeout out of range");

    // a waiting beat holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_fired_id) && $stable(o_next_timeout)))
        else $error("waiting result beat changed");
endmodule

bind timer_queue_expiry_engine_unit tqe_checker u_tqe_checker (.*);
